>>> rtl/hcfh_pkg.sv
// Shared types, constants and quarter-sine table for the harmonic coefficient block.
`default_nettype none

package hcfh_pkg;

  localparam int unsigned COS_TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W           = $clog2(COS_TABLE_DEPTH);
  localparam int unsigned QTR             = COS_TABLE_DEPTH / 4;
  localparam int unsigned QTR_W           = IDX_W - 2;

  localparam int unsigned ORDER_W   = 3;
  localparam int unsigned PHASE_W   = 16;
  localparam int unsigned CONTENT_W = 32;
  localparam int unsigned ERROR_W   = 32;
  localparam int unsigned COS_W     = 16;
  localparam int unsigned PROD_W    = 48;
  localparam int unsigned ERRMAG_W  = ERROR_W + COS_W - 1;
  localparam int unsigned E16_W     = 32;
  localparam int unsigned SUM_W     = 64;
  localparam int unsigned TOTAL_W   = 48;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned UNC_W     = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned ROOT_W    = SUM_W / 2;

  localparam int unsigned COEF_SHIFT = 15;
  localparam int unsigned UNC_SHIFT  = 8;
  localparam int unsigned COEF_STEPS = COEF_W + 1;
  localparam int unsigned HI_SHIFT   = COEF_STEPS - COEF_SHIFT;
  localparam int unsigned ROOT_STEPS = ROOT_W;
  localparam int unsigned UNC_STEPS  = ROOT_W + UNC_SHIFT;
  localparam int unsigned DVD_W      = UNC_STEPS;
  localparam int unsigned CNT_W      = $clog2(UNC_STEPS + 1);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(2);
  localparam logic [ORDER_W-1:0] MAX_ORDER   = ORDER_W'(5);

  localparam logic [63:0] SIN_A = 64'd1686629713;
  localparam logic [63:0] SIN_B = 64'd693598670;
  localparam logic [63:0] SIN_C = 64'd85569306;
  localparam logic [63:0] SIN_D = 64'd5026995;
  localparam logic [63:0] SIN_E = 64'd172272;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_ORDER = 2'd1,
    ST_ZERO  = 2'd2,
    ST_SAT   = 2'd3
  } status_e;

  typedef struct packed {
    logic [CONTENT_W-1:0]    content;
    logic [ERROR_W-1:0]      err;
    logic signed [COS_W-1:0] cos;
    logic                    last;
    logic                    bad_order;
  } item_t;

  typedef struct packed {
    logic [SUM_W-1:0]   wsum;
    logic [SUM_W-1:0]   esum;
    logic [TOTAL_W-1:0] total;
    logic               bad_order;
  } fin_req_t;

  typedef logic [QTR-1:0][COS_W-2:0] qs_rom_t;

  function automatic logic [COS_W-2:0] quarter_sine(input logic [63:0] q);
    logic [63:0] q2;
    logic [63:0] t;
    logic [63:0] s;
    q2 = (q * q) >> 30;
    t  = SIN_E;
    t  = SIN_D - ((t * q2) >> 30);
    t  = SIN_C - ((t * q2) >> 30);
    t  = SIN_B - ((t * q2) >> 30);
    t  = SIN_A - ((t * q2) >> 30);
    s  = (t * q) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[COS_W-2:0];
  endfunction

  function automatic qs_rom_t build_qs_rom();
    qs_rom_t rom;
    for (int m = 0; m < QTR; m++) begin
      rom[m] = quarter_sine(64'(m) << (30 - QTR_W));
    end
    return rom;
  endfunction

  localparam qs_rom_t          QS_ROM = build_qs_rom();
  localparam logic [COS_W-2:0] QS_TOP = quarter_sine(64'd1 << 30);

endpackage

`default_nettype wire

>>> rtl/hcfh_if.sv
// Bin and result channel interfaces.
`default_nettype none

interface hcfh_bin_if;
  logic                                 valid;
  logic                                 ready;
  logic [hcfh_pkg::CONTENT_W-1:0]       bin_content;
  logic [hcfh_pkg::ERROR_W-1:0]         bin_error;
  logic signed [hcfh_pkg::PHASE_W-1:0]  bin_phase;
  logic                                 last_bin;

  modport source (output valid, bin_content, bin_error, bin_phase, last_bin, input ready);
  modport sink (input valid, bin_content, bin_error, bin_phase, last_bin, output ready);
endinterface

interface hcfh_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [hcfh_pkg::COEF_W-1:0]  coefficient;
  logic [hcfh_pkg::UNC_W-1:0]          uncertainty;
  logic [hcfh_pkg::STATUS_W-1:0]       status;

  modport source (output valid, coefficient, uncertainty, status, input ready);
  modport sink (input valid, coefficient, uncertainty, status, output ready);
endinterface

`default_nettype wire

>>> rtl/hcfh_front.sv
// Front end: order register, cosine lookup and bin capture.
`default_nettype none

module hcfh_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hcfh_pkg::ORDER_W-1:0]    cfg_wdata_i,
  hcfh_bin_if.sink                        bin_i,
  output logic                            push_valid_o,
  input  logic                            push_ready_i,
  output hcfh_pkg::item_t                 push_item_o
);

  localparam int unsigned AF_W = hcfh_pkg::PHASE_W + hcfh_pkg::ORDER_W;

  logic [hcfh_pkg::ORDER_W-1:0] order_q;
  logic                         f_valid_q, f_valid_d;
  hcfh_pkg::item_t              f_item_q;
  hcfh_pkg::item_t              item_d;

  logic [AF_W-1:0]                   angle_full;
  logic [hcfh_pkg::PHASE_W-1:0]      angle;
  logic [hcfh_pkg::IDX_W-1:0]        idx;
  logic [hcfh_pkg::IDX_W-1:0]        j;
  logic [1:0]                        quad;
  logic [hcfh_pkg::QTR_W-1:0]        m;
  logic [hcfh_pkg::QTR_W:0]          arg;
  logic [hcfh_pkg::COS_W-2:0]        mag;
  logic                              accept;

  assign angle_full = {{hcfh_pkg::PHASE_W{1'b0}}, order_q}
                    * {{hcfh_pkg::ORDER_W{1'b0}}, bin_i.bin_phase};
  assign angle = angle_full[hcfh_pkg::PHASE_W-1:0];
  assign idx   = angle[hcfh_pkg::PHASE_W-1 -: hcfh_pkg::IDX_W];
  assign j     = idx + hcfh_pkg::IDX_W'(hcfh_pkg::QTR);
  assign quad  = j[hcfh_pkg::IDX_W-1 -: 2];
  assign m     = j[hcfh_pkg::QTR_W-1:0];
  assign arg   = quad[0] ? ((hcfh_pkg::QTR_W+1)'(hcfh_pkg::QTR) - {1'b0, m}) : {1'b0, m};
  assign mag   = arg[hcfh_pkg::QTR_W] ? hcfh_pkg::QS_TOP
                                      : hcfh_pkg::QS_ROM[arg[hcfh_pkg::QTR_W-1:0]];

  always_comb begin
    item_d.content   = bin_i.bin_content;
    item_d.err       = bin_i.bin_error;
    item_d.cos       = quad[1] ? hcfh_pkg::COS_W'(hcfh_pkg::COS_W'(0) - {1'b0, mag})
                               : {1'b0, mag};
    item_d.last      = bin_i.last_bin;
    item_d.bad_order = order_q > hcfh_pkg::MAX_ORDER;
  end

  assign bin_i.ready  = !f_valid_q || push_ready_i;
  assign accept       = bin_i.valid && bin_i.ready;
  assign f_valid_d    = accept || (f_valid_q && !push_ready_i);
  assign push_valid_o = f_valid_q;
  assign push_item_o  = f_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q   <= hcfh_pkg::ORDER_RESET;
      f_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hcfh_queue.sv
// Two-word queue between front end and accumulator.
`default_nettype none

module hcfh_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  hcfh_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output hcfh_pkg::item_t pop_item_o
);

  hcfh_pkg::item_t               mem_q [hcfh_pkg::QUEUE_DEPTH];
  logic [hcfh_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [hcfh_pkg::QCNT_W-1:0]   count_q, count_d;
  logic                          push, pop;

  assign push_ready_o = count_q != hcfh_pkg::QCNT_W'(hcfh_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hcfh_accum.sv
// Accumulator pipeline: products, squared error and saturating sums.
`default_nettype none

module hcfh_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  hcfh_pkg::item_t    pop_item_i,
  output logic               fin_valid_o,
  input  logic               fin_ready_i,
  output hcfh_pkg::fin_req_t fin_req_o
);

  localparam int unsigned PF_W = hcfh_pkg::CONTENT_W + hcfh_pkg::COS_W + 1;

  logic                                s1_valid_q, s2_valid_q;
  logic signed [hcfh_pkg::PROD_W-1:0]  s1_prod_q, s2_prod_q;
  logic [hcfh_pkg::ERRMAG_W-1:0]       s1_errmag_q;
  logic [hcfh_pkg::CONTENT_W-1:0]      s1_content_q, s2_content_q;
  logic                                s1_last_q, s2_last_q;
  logic                                s1_bad_q, s2_bad_q;
  logic [hcfh_pkg::SUM_W-1:0]          s2_sq_q;

  logic [hcfh_pkg::SUM_W-1:0]          wsum_q, esum_q;
  logic [hcfh_pkg::TOTAL_W-1:0]        total_q;

  logic                                adv, pop;
  logic [hcfh_pkg::COS_W-1:0]          cos_neg;
  logic [hcfh_pkg::COS_W-2:0]          cos_abs;
  logic signed [PF_W-1:0]              prod_full;
  logic [hcfh_pkg::ERRMAG_W-1:0]       errmag;
  logic [hcfh_pkg::ERRMAG_W-1:0]       errmag_rnd;
  logic [hcfh_pkg::E16_W-1:0]          e16;

  logic [hcfh_pkg::SUM_W:0]            wsum_add, esum_add;
  logic [hcfh_pkg::TOTAL_W:0]          total_add;
  logic [hcfh_pkg::SUM_W-1:0]          wsum_n, esum_n;
  logic [hcfh_pkg::TOTAL_W-1:0]        total_n;

  assign adv         = !(s2_valid_q && s2_last_q && !fin_ready_i);
  assign pop_ready_o = adv;
  assign pop         = pop_valid_i && adv;

  assign cos_neg   = hcfh_pkg::COS_W'(0) - pop_item_i.cos;
  assign cos_abs   = pop_item_i.cos[hcfh_pkg::COS_W-1] ? cos_neg[hcfh_pkg::COS_W-2:0]
                                                       : pop_item_i.cos[hcfh_pkg::COS_W-2:0];
  assign prod_full = $signed({1'b0, pop_item_i.content}) * $signed(pop_item_i.cos);
  assign errmag    = pop_item_i.err * cos_abs;

  assign errmag_rnd = s1_errmag_q + hcfh_pkg::ERRMAG_W'(16384);
  assign e16        = errmag_rnd[hcfh_pkg::COEF_SHIFT +: hcfh_pkg::E16_W];

  assign wsum_add = {wsum_q[hcfh_pkg::SUM_W-1], wsum_q}
                  + {{(hcfh_pkg::SUM_W - hcfh_pkg::PROD_W + 1){s2_prod_q[hcfh_pkg::PROD_W-1]}},
                     s2_prod_q};
  assign esum_add  = {1'b0, esum_q} + {1'b0, s2_sq_q};
  assign total_add = {1'b0, total_q}
                   + {{(hcfh_pkg::TOTAL_W - hcfh_pkg::CONTENT_W + 1){1'b0}}, s2_content_q};

  always_comb begin
    if (wsum_add[hcfh_pkg::SUM_W] != wsum_add[hcfh_pkg::SUM_W-1]) begin
      wsum_n = wsum_add[hcfh_pkg::SUM_W] ? {1'b1, {(hcfh_pkg::SUM_W-1){1'b0}}}
                                         : {1'b0, {(hcfh_pkg::SUM_W-1){1'b1}}};
    end else begin
      wsum_n = wsum_add[hcfh_pkg::SUM_W-1:0];
    end
    esum_n  = esum_add[hcfh_pkg::SUM_W] ? '1 : esum_add[hcfh_pkg::SUM_W-1:0];
    total_n = total_add[hcfh_pkg::TOTAL_W] ? '1 : total_add[hcfh_pkg::TOTAL_W-1:0];
  end

  assign fin_valid_o         = s2_valid_q && s2_last_q;
  assign fin_req_o.wsum      = wsum_n;
  assign fin_req_o.esum      = esum_n;
  assign fin_req_o.total     = total_n;
  assign fin_req_o.bad_order = s2_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      wsum_q     <= '0;
      esum_q     <= '0;
      total_q    <= '0;
    end else if (adv) begin
      s1_valid_q <= pop;
      s2_valid_q <= s1_valid_q;
      if (s2_valid_q) begin
        if (s2_last_q) begin
          wsum_q  <= '0;
          esum_q  <= '0;
          total_q <= '0;
        end else begin
          wsum_q  <= wsum_n;
          esum_q  <= esum_n;
          total_q <= total_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_prod_q    <= prod_full[hcfh_pkg::PROD_W-1:0];
      s1_errmag_q  <= errmag;
      s1_content_q <= pop_item_i.content;
      s1_last_q    <= pop_item_i.last;
      s1_bad_q     <= pop_item_i.bad_order;
      s2_prod_q    <= s1_prod_q;
      s2_sq_q      <= e16 * e16;
      s2_content_q <= s1_content_q;
      s2_last_q    <= s1_last_q;
      s2_bad_q     <= s1_bad_q;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hcfh_final.sv
// Result unit: serial divider and square root, output register.
`default_nettype none

module hcfh_final (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fin_valid_i,
  output logic               fin_ready_o,
  input  hcfh_pkg::fin_req_t fin_req_i,
  hcfh_res_if.source         res_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_COEF = 2'd1;
  localparam logic [1:0] S_UNC  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam int unsigned HI_W   = hcfh_pkg::SUM_W - hcfh_pkg::HI_SHIFT;
  localparam int unsigned SREM_W = hcfh_pkg::ROOT_W + 2;
  localparam int unsigned ST_W   = SREM_W + 2;

  localparam logic [hcfh_pkg::COEF_STEPS-1:0] NEG_LIM = hcfh_pkg::COEF_STEPS'(33'h0_8000_0000);
  localparam logic [hcfh_pkg::COEF_STEPS-1:0] POS_LIM = hcfh_pkg::COEF_STEPS'(33'h0_7FFF_FFFF);

  logic [1:0]                       state_q, state_d;
  logic [hcfh_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [hcfh_pkg::TOTAL_W-1:0]     tot_q, tot_d;
  logic                             neg_q, neg_d;
  logic                             covf_q, covf_d;
  logic                             csat_q, csat_d;
  logic [hcfh_pkg::TOTAL_W-1:0]     rem_q, rem_d;
  logic [hcfh_pkg::DVD_W-1:0]       dvd_q, dvd_d;
  logic [hcfh_pkg::DVD_W-1:0]       quo_q, quo_d;
  logic [hcfh_pkg::SUM_W-1:0]       x_q, x_d;
  logic [hcfh_pkg::ROOT_W-1:0]      root_q, root_d;
  logic [SREM_W-1:0]                srem_q, srem_d;
  logic [hcfh_pkg::COEF_W-1:0]      coef_q, coef_d;
  logic [hcfh_pkg::UNC_W-1:0]       unc_q, unc_d;
  hcfh_pkg::status_e                status_q, status_d;

  logic [hcfh_pkg::SUM_W-1:0]       mag;
  logic [hcfh_pkg::TOTAL_W:0]       r2;
  logic                             qbit;
  logic [hcfh_pkg::TOTAL_W-1:0]     rem_n;
  logic [ST_W-1:0]                  st, trial;
  logic                             sge;
  logic [SREM_W-1:0]                srem_n;
  logic [hcfh_pkg::ROOT_W-1:0]      root_n;
  logic [hcfh_pkg::COEF_STEPS-1:0]  q;
  logic [hcfh_pkg::DVD_W-1:0]       uq;
  logic                             usat;

  assign mag = fin_req_i.wsum[hcfh_pkg::SUM_W-1] ? (hcfh_pkg::SUM_W'(0) - fin_req_i.wsum)
                                                 : fin_req_i.wsum;

  assign r2    = {rem_q, dvd_q[hcfh_pkg::DVD_W-1]};
  assign qbit  = r2 >= {1'b0, tot_q};
  assign rem_n = qbit ? hcfh_pkg::TOTAL_W'(r2 - {1'b0, tot_q}) : r2[hcfh_pkg::TOTAL_W-1:0];

  assign st     = {srem_q, x_q[hcfh_pkg::SUM_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign sge    = st >= trial;
  assign srem_n = sge ? SREM_W'(st - trial) : st[SREM_W-1:0];
  assign root_n = {root_q[hcfh_pkg::ROOT_W-2:0], sge};

  assign q    = {quo_q[hcfh_pkg::COEF_STEPS-2:0], qbit};
  assign uq   = {quo_q[hcfh_pkg::DVD_W-2:0], qbit};
  assign usat = |uq[hcfh_pkg::DVD_W-1:hcfh_pkg::UNC_W];

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    tot_d    = tot_q;
    neg_d    = neg_q;
    covf_d   = covf_q;
    csat_d   = csat_q;
    rem_d    = rem_q;
    dvd_d    = dvd_q;
    quo_d    = quo_q;
    x_d      = x_q;
    root_d   = root_q;
    srem_d   = srem_q;
    coef_d   = coef_q;
    unc_d    = unc_q;
    status_d = status_q;
    case (state_q)
      S_IDLE: begin
        if (fin_valid_i) begin
          tot_d  = fin_req_i.total;
          neg_d  = fin_req_i.wsum[hcfh_pkg::SUM_W-1];
          covf_d = {{(hcfh_pkg::TOTAL_W-HI_W){1'b0}}, mag[hcfh_pkg::SUM_W-1:hcfh_pkg::HI_SHIFT]}
                   >= fin_req_i.total;
          rem_d  = {{(hcfh_pkg::TOTAL_W-HI_W){1'b0}}, mag[hcfh_pkg::SUM_W-1:hcfh_pkg::HI_SHIFT]};
          dvd_d  = {mag[hcfh_pkg::HI_SHIFT-1:0],
                    {(hcfh_pkg::DVD_W-hcfh_pkg::HI_SHIFT){1'b0}}};
          quo_d  = '0;
          x_d    = fin_req_i.esum;
          root_d = '0;
          srem_d = '0;
          cnt_d  = '0;
          csat_d = 1'b0;
          coef_d = '0;
          unc_d  = '0;
          if (fin_req_i.bad_order) begin
            status_d = hcfh_pkg::ST_ORDER;
            state_d  = S_DONE;
          end else if (fin_req_i.total == '0) begin
            status_d = hcfh_pkg::ST_ZERO;
            state_d  = S_DONE;
          end else begin
            if (covf_d) begin
              rem_d = '0;
            end
            state_d = S_COEF;
          end
        end
      end
      S_COEF: begin
        rem_d = rem_n;
        dvd_d = {dvd_q[hcfh_pkg::DVD_W-2:0], 1'b0};
        quo_d = {quo_q[hcfh_pkg::DVD_W-2:0], qbit};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q < hcfh_pkg::CNT_W'(hcfh_pkg::ROOT_STEPS)) begin
          x_d    = {x_q[hcfh_pkg::SUM_W-3:0], 2'b00};
          root_d = root_n;
          srem_d = srem_n;
        end
        if (cnt_q == hcfh_pkg::CNT_W'(hcfh_pkg::COEF_STEPS - 1)) begin
          if (neg_q) begin
            csat_d = covf_q || (q > NEG_LIM);
            coef_d = csat_d ? {1'b1, {(hcfh_pkg::COEF_W-1){1'b0}}}
                            : hcfh_pkg::COEF_W'(hcfh_pkg::COEF_STEPS'(0) - q);
          end else begin
            csat_d = covf_q || (q > POS_LIM);
            coef_d = csat_d ? {1'b0, {(hcfh_pkg::COEF_W-1){1'b1}}}
                            : q[hcfh_pkg::COEF_W-1:0];
          end
          rem_d   = '0;
          dvd_d   = {root_q, {hcfh_pkg::UNC_SHIFT{1'b0}}};
          quo_d   = '0;
          cnt_d   = '0;
          state_d = S_UNC;
        end
      end
      S_UNC: begin
        rem_d = rem_n;
        dvd_d = {dvd_q[hcfh_pkg::DVD_W-2:0], 1'b0};
        quo_d = {quo_q[hcfh_pkg::DVD_W-2:0], qbit};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == hcfh_pkg::CNT_W'(hcfh_pkg::UNC_STEPS - 1)) begin
          unc_d    = usat ? '1 : uq[hcfh_pkg::UNC_W-1:0];
          status_d = (csat_q || usat) ? hcfh_pkg::ST_SAT : hcfh_pkg::ST_OK;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (res_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign fin_ready_o       = state_q == S_IDLE;
  assign res_o.valid       = state_q == S_DONE;
  assign res_o.coefficient = coef_q;
  assign res_o.uncertainty = unc_q;
  assign res_o.status      = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tot_q    <= tot_d;
    neg_q    <= neg_d;
    covf_q   <= covf_d;
    csat_q   <= csat_d;
    rem_q    <= rem_d;
    dvd_q    <= dvd_d;
    quo_q    <= quo_d;
    x_q      <= x_d;
    root_q   <= root_d;
    srem_q   <= srem_d;
    coef_q   <= coef_d;
    unc_q    <= unc_d;
    status_q <= status_d;
  end

endmodule

`default_nettype wire

>>> rtl/harmonic_coefficient_from_histogram_top.sv
// Path: a bin word passes the front register, queue and accumulator stages s1, s2
// before the sums. A result follows its last bin after 33 coefficient divide steps
// (square root alongside), then 40 uncertainty steps in the shared serial divider.
// Throughput: one bin per cycle; a last bin stalls only while the previous result
// is still being computed or waiting at the output.
// Reset: asynchronous, active low; clears sums, queue and control, order reads 2.
`default_nettype none

module harmonic_coefficient_from_histogram_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hcfh_pkg::ORDER_W-1:0]  cfg_wdata_i,
  hcfh_bin_if.sink                      bin_i,
  hcfh_res_if.source                    res_o
);

  logic               push_valid, push_ready;
  hcfh_pkg::item_t    push_item;
  logic               pop_valid, pop_ready;
  hcfh_pkg::item_t    pop_item;
  logic               fin_valid, fin_ready;
  hcfh_pkg::fin_req_t fin_req;

  hcfh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .bin_i        (bin_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  hcfh_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  hcfh_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .fin_valid_o (fin_valid),
    .fin_ready_i (fin_ready),
    .fin_req_o   (fin_req)
  );

  hcfh_final u_final (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fin_valid_i (fin_valid),
    .fin_ready_o (fin_ready),
    .fin_req_i   (fin_req),
    .res_o       (res_o)
  );

  a_fin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid && fin_ready |=> !fin_ready)
    else $error("result unit still idle after taking a histogram");

  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !fin_ready)
    else $error("result unit idle while a result is pending");

  a_zero_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status == hcfh_pkg::ST_ORDER || res_o.status == hcfh_pkg::ST_ZERO)
    |-> res_o.coefficient == '0 && res_o.uncertainty == '0)
    else $error("nonzero result with order or zero-total status");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the harmonic coefficient block: bin traffic against a scoreboard.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hcfh_pkg::*;

  class harmonic_scoreboard;
    typedef struct {
      logic signed [COEF_W-1:0] coefficient;
      logic [UNC_W-1:0]         uncertainty;
      status_e                  status;
    } coef_word_t;

    logic [ORDER_W-1:0]      order;
    logic signed [COS_W-1:0] cos_lut [COS_TABLE_DEPTH];
    logic [SUM_W-1:0]        weighted_sum;
    logic [SUM_W-1:0]        error_sq_sum;
    logic [TOTAL_W-1:0]      content_total;
    coef_word_t              expected_words [$];
    int unsigned             failures;
    int unsigned             words_checked;

    function logic [63:0] sine_q15(logic [63:0] q);
      logic [63:0] horner [4];
      logic [63:0] q2;
      logic [63:0] acc;
      horner = '{SIN_D, SIN_C, SIN_B, SIN_A};
      q2     = (q * q) >> 30;
      acc    = SIN_E;
      foreach (horner[i]) acc = horner[i] - ((acc * q2) >> 30);
      acc = (((acc * q) >> 30) + 64'd16384) >> 15;
      return (acc > 64'd32767) ? 64'd32767 : acc;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= x) root = trial;
      end
      return root;
    endfunction

    function void clear_sums();
      weighted_sum  = '0;
      error_sq_sum  = '0;
      content_total = '0;
    endfunction

    function new();
      logic [63:0] frac;
      logic [63:0] turn;
      logic [63:0] rem;
      logic [63:0] v;
      for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
        frac = (64'(k) << 32) / COS_TABLE_DEPTH;
        turn = (frac + (64'd1 << 30)) & 64'hFFFF_FFFF;
        rem  = turn & ((64'd1 << 30) - 64'd1);
        v    = turn[30] ? sine_q15((64'd1 << 30) - rem) : sine_q15(rem);
        cos_lut[k] = turn[31] ? -v[15:0] : v[15:0];
      end
      order         = ORDER_RESET;
      failures      = 0;
      words_checked = 0;
      clear_sums();
    endfunction

    function void note_bin(logic [31:0] content, logic [31:0] err, logic [15:0] phase,
                           logic is_last);
      logic [18:0]             turns;
      logic [31:0]             idx;
      logic signed [COS_W-1:0] c;
      logic [15:0]             mag_c;
      logic [63:0]             prod, e16, sq, mag, q1, r1, q, tot, root, unc;
      logic [64:0]             wide;
      logic [48:0]             grown;
      logic                    sat;
      coef_word_t              w;
      turns = order * phase;
      idx   = (32'(turns[15:0]) * COS_TABLE_DEPTH) >> 16;
      if (idx >= COS_TABLE_DEPTH) idx = COS_TABLE_DEPTH - 1;
      c = cos_lut[idx];

      prod = {32'd0, content} * {{48{c[15]}}, c};
      wide = {weighted_sum[63], weighted_sum} + {prod[63], prod};
      if (wide[64] != wide[63]) begin
        weighted_sum = wide[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end else begin
        weighted_sum = wide[63:0];
      end

      mag_c = c[15] ? -c : c;
      e16   = (64'(err) * 64'(mag_c) + 64'd16384) >> 15;
      sq    = e16 * e16;
      wide  = {1'b0, error_sq_sum} + {1'b0, sq};
      error_sq_sum = wide[64] ? '1 : wide[63:0];

      grown = {1'b0, content_total} + 49'(content);
      content_total = grown[48] ? '1 : grown[47:0];

      if (!is_last) return;

      w.coefficient = '0;
      w.uncertainty = '0;
      if (order > MAX_ORDER) begin
        w.status = ST_ORDER;
      end else if (content_total == '0) begin
        w.status = ST_ZERO;
      end else begin
        sat = 1'b0;
        tot = 64'(content_total);
        mag = weighted_sum[63] ? -weighted_sum : weighted_sum;
        q1  = mag / tot;
        r1  = mag % tot;
        q   = (q1 >= (64'd1 << 17)) ? (64'd1 << 32) : ((q1 << 15) + ((r1 << 15) / tot));
        if (weighted_sum[63]) begin
          if (q > 64'h8000_0000) begin
            q   = 64'h8000_0000;
            sat = 1'b1;
          end
          w.coefficient = -q[31:0];
        end else begin
          if (q > 64'h7FFF_FFFF) begin
            q   = 64'h7FFF_FFFF;
            sat = 1'b1;
          end
          w.coefficient = q[31:0];
        end
        root = int_sqrt(error_sq_sum);
        unc  = (root << 8) / tot;
        if (unc > 64'hFFFF_FFFF) begin
          unc = 64'hFFFF_FFFF;
          sat = 1'b1;
        end
        w.uncertainty = unc[31:0];
        w.status      = sat ? ST_SAT : ST_OK;
      end
      expected_words = {expected_words, w};
      clear_sums();
    endfunction

    function void check_result(logic signed [COEF_W-1:0] coefficient,
                               logic [UNC_W-1:0] uncertainty, logic [STATUS_W-1:0] status);
      coef_word_t w;
      if (expected_words.size() == 0) begin
        failures++;
        $display("%0t: result word expected none, actual coefficient %0d",
                 $time, coefficient);
        $display("%0t: uncertainty %0d status %0d", $time, uncertainty, status);
        return;
      end
      w = expected_words.pop_front();
      words_checked++;
      if (coefficient !== w.coefficient) begin
        failures++;
        $display("%0t: coefficient expected %0d actual %0d", $time, w.coefficient, coefficient);
      end
      if (uncertainty !== w.uncertainty) begin
        failures++;
        $display("%0t: uncertainty expected %0d actual %0d", $time, w.uncertainty, uncertainty);
      end
      if (status !== w.status) begin
        failures++;
        $display("%0t: status expected %0d actual %0d", $time, w.status, status);
      end
    endfunction
  endclass

  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned SAT_BINS     = 30;
  localparam int unsigned PHASE_BINS   = 50;
  localparam logic [ORDER_W-1:0] ORDER_SWEEP [8] = '{3'd0, 3'd7, 3'd5, 3'd1, 3'd3, 3'd6,
                                                     3'd4, 3'd2};

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [ORDER_W-1:0] cfg_wdata;
  logic               no_idle;
  int unsigned        holds_requested;
  int unsigned        bins_sent;
  harmonic_scoreboard scoreboard;

  hcfh_bin_if bin_bus ();
  hcfh_res_if res_bus ();

  harmonic_coefficient_from_histogram_top DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .bin_i      (bin_bus),
    .res_o      (res_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_bin(logic [31:0] content, logic [31:0] err, logic [15:0] phase,
                          logic is_last);
    while (!no_idle && $urandom_range(99, 0) < 17) begin
      bin_bus.valid <= 1'b0;
      @(posedge clk);
    end
    bin_bus.valid       <= 1'b1;
    bin_bus.bin_content <= content;
    bin_bus.bin_error   <= err;
    bin_bus.bin_phase   <= phase;
    bin_bus.last_bin    <= is_last;
    @(posedge clk);
    while (!bin_bus.ready) @(posedge clk);
    scoreboard.note_bin(content, err, phase, is_last);
    bins_sent++;
  endtask

  task automatic send_histogram(int unsigned nbins, bit no_content, bit with_last);
    logic [31:0] content;
    logic [31:0] err;
    logic [15:0] phase;
    for (int unsigned i = 0; i < nbins; i++) begin
      case ($urandom_range(9, 0))
        0:          content = '0;
        1:          content = '1;
        2, 3, 4, 5: content = $urandom_range(1000, 0);
        default:    content = $urandom();
      endcase
      case ($urandom_range(9, 0))
        0:          err = '0;
        1:          err = '1;
        2, 3, 4, 5: err = $urandom_range(32'h0010_0000, 0);
        default:    err = $urandom();
      endcase
      case ($urandom_range(9, 0))
        0:       phase = 16'h8000;
        1:       phase = 16'h7FFF;
        2:       phase = 16'h0000;
        default: phase = $urandom();
      endcase
      send_bin(no_content ? 32'd0 : content, err, phase, with_last && (i == nbins - 1));
    end
  endtask

  task automatic wait_results();
    bin_bus.valid <= 1'b0;
    while (scoreboard.expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic set_order(logic [ORDER_W-1:0] value);
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    scoreboard.order = value;
  endtask

  initial begin
    int unsigned holds_seen;
    int unsigned hold_left;
    holds_seen = 0;
    hold_left  = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_bus.valid && res_bus.ready) begin
        scoreboard.check_result(res_bus.coefficient, res_bus.uncertainty, res_bus.status);
      end
      if (holds_requested != holds_seen) begin
        holds_seen = holds_requested;
        hold_left  = LONG_HOLD;
      end
      res_bus.ready <= rst_n && (hold_left == 0) && (no_idle || $urandom_range(99, 0) >= 17);
      if (hold_left != 0) hold_left--;
    end
  end

  initial begin
    int unsigned phase_start;
    scoreboard      = new();
    bins_sent       = 0;
    holds_requested = 0;
    no_idle         = 1'b0;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    bin_bus.valid       <= 1'b0;
    bin_bus.bin_content <= '0;
    bin_bus.bin_error   <= '0;
    bin_bus.bin_phase   <= '0;
    bin_bus.last_bin    <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_bin(32'd100, 32'h0001_0000, 16'h0000, 1'b1);
    send_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 1'b0);
    send_bin(32'hFFFF_FFFF, 32'h0000_0000, 16'h7FFF, 1'b1);
    send_bin(32'd0, 32'hFFFF_FFFF, 16'h4000, 1'b1);
    send_bin(32'd1, 32'hFFFF_FFFF, 16'h0000, 1'b1);
    send_bin(32'd1, 32'hFFFF_FFFF, 16'h0000, 1'b0);
    send_bin(32'd1, 32'hFFFF_FFFF, 16'h0000, 1'b0);
    send_bin(32'd1, 32'hFFFF_FFFF, 16'h0000, 1'b1);
    send_bin(32'd5000, 32'h0000_8000, 16'd12345, 1'b0);
    send_bin(32'd7000, 32'h0003_0000, -16'sd2000, 1'b0);
    set_order(3'd6);
    send_bin(32'd10, 32'h0000_0100, 16'd4000, 1'b1);
    set_order(3'd3);
    send_bin(32'd300, 32'h0002_0000, 16'd1000, 1'b0);
    set_order(3'd1);
    send_bin(32'd900, 32'h0000_4000, 16'd20000, 1'b1);
    set_order(3'd0);
    send_bin(32'd50, 32'h0002_0000, -16'sd12345, 1'b1);
    set_order(3'd7);
    send_bin(32'd0, 32'h0000_0000, 16'h8000, 1'b1);
    set_order(3'd5);
    send_bin(32'd77, 32'h0000_1234, 16'd9999, 1'b1);

    // push a solid run of full content at half a turn
    set_order(3'd1);
    no_idle <= 1'b1;
    for (int unsigned i = 0; i < SAT_BINS; i++) begin
      send_bin(32'hFFFF_FFFF, $urandom_range(65535, 0), 16'h8000, i == SAT_BINS - 1);
    end
    no_idle <= 1'b0;

    for (int p = 0; p < 10; p++) begin
      if ($urandom_range(2, 0) == 0) send_histogram($urandom_range(6, 1), 1'b0, 1'b0);
      set_order(p < 8 ? ORDER_SWEEP[p] : 3'($urandom_range(7, 0)));
      no_idle <= (p == 2);
      // hold off the result side while short histograms keep coming
      if (p == 5) holds_requested <= holds_requested + 1;
      phase_start = bins_sent;
      while (bins_sent - phase_start < PHASE_BINS) begin
        if (p == 5) begin
          send_histogram($urandom_range(2, 1), 1'b0, 1'b1);
        end else if ($urandom_range(9, 0) == 0) begin
          send_histogram($urandom_range(40, 13), $urandom_range(11, 0) == 0, 1'b1);
        end else begin
          send_histogram($urandom_range(12, 1), $urandom_range(11, 0) == 0, 1'b1);
        end
      end
    end
    no_idle <= 1'b0;

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d bins across harmonic orders 0 to 7, with a saturated error sum",
             bins_sent);
    $display("Checked %0d result words, %0d mismatches", scoreboard.words_checked,
             scoreboard.failures);
    if (scoreboard.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/hcfh_pkg.sv
rtl/hcfh_if.sv
rtl/hcfh_front.sv
rtl/hcfh_queue.sv
rtl/hcfh_accum.sv
rtl/hcfh_final.sv
rtl/harmonic_coefficient_from_histogram_top.sv
verif/tb_top.sv
